// ===== src/mmsf_pkg.sv =====
package mmsf_pkg;

	// history and field widths
	localparam int HIST_DEPTH = 10;
	localparam int IDX_W      = $clog2(HIST_DEPTH);
	localparam int POS_W      = 32;
	localparam int CFG_W      = 16;
	localparam int WT_W       = 17;

	// the weight sum stays below HIST_DEPTH * 1.0 in Q16.16
	localparam int TOT_W  = $clog2(HIST_DEPTH * 65536);
	localparam int PROD_W = POS_W + WT_W;
	localparam int ACC_W  = POS_W + TOT_W;
	localparam int MAG_W  = ACC_W;
	localparam int CNT_W  = $clog2(MAG_W + 1);

	localparam logic [WT_W-1:0]  WT_ONE      = WT_W'(65536);
	localparam logic [CFG_W-1:0] DECAY_RESET = CFG_W'(13107);
	localparam int               RND_HALF    = 32768;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_MX   = 8'b0000_0100,
		S_MY   = 8'b0000_1000,
		S_AY   = 8'b0001_0000,
		S_DVX  = 8'b0010_0000,
		S_DVY  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] num;
		logic [TOT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [MAG_W-1:0] quo;
	} div_rsp_t;

endpackage

// ===== src/mmsf_ram.sv =====
module mmsf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/mmsf_div.sv =====
module mmsf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mmsf_pkg::div_req_t req,
	output mmsf_pkg::div_rsp_t rsp
);

	logic [mmsf_pkg::TOT_W-1:0] rem_q;
	logic [mmsf_pkg::TOT_W-1:0] den_q;
	logic [mmsf_pkg::MAG_W-1:0] num_q;
	logic [mmsf_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;

	logic [mmsf_pkg::TOT_W:0] trial;
	logic [mmsf_pkg::TOT_W:0] diff;
	logic                     ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, num_q[mmsf_pkg::MAG_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= mmsf_pkg::CNT_W'(mmsf_pkg::MAG_W);
		end else if (busy_q && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			num_q <= req.num;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= ge ? diff[mmsf_pkg::TOT_W-1:0] : trial[mmsf_pkg::TOT_W-1:0];
			num_q <= {num_q[mmsf_pkg::MAG_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = busy_q && (cnt_q == '0);
	assign rsp.quo  = num_q;

endmodule

// ===== src/mouse_motion_smoothing_filter.sv =====
// mouse motion smoothing filter: each transaction on the item channel carries either an
// absolute cursor position (kind 0) or a relative movement (kind 1) for both axes, signed
// Q24.8. cursor positions become movements against the last cursor position; the very
// first cursor transaction only records the position and produces no result. each movement
// enters a ten-entry history, the filter takes the weighted mean with weights 1, w, w^2 ...
// (w = weight_decay, unsigned Q0.16, reset about 0.2), newest first, and the result is the
// mean of that value and the previous mean, rounded and saturated. item_stall is high while
// an item is worked on: one shared multiplier steps through the history tap by tap in the
// states S_MX, S_MY and S_AY, then a radix-2 divider runs once per axis; the first cursor
// item raises no stall. a finished result waits in an output register, so the next item is
// taken meanwhile. weight_decay is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while the block is idle, which the block itself does not enforce.
module mouse_motion_smoothing_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [mmsf_pkg::CFG_W-1:0]        cfg_wr_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              kind,
	input  logic signed [mmsf_pkg::POS_W-1:0] pos_x,
	input  logic signed [mmsf_pkg::POS_W-1:0] pos_y,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [mmsf_pkg::POS_W-1:0] move_x,
	output logic signed [mmsf_pkg::POS_W-1:0] move_y
);

	localparam int PW = mmsf_pkg::POS_W;

	// saturate a 33-bit difference to 32 bits
	function automatic logic [PW-1:0] sat33(input logic [PW:0] v);
		logic [PW-1:0] r;
		if (v[PW] != v[PW-1]) begin
			r = v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		end else begin
			r = v[PW-1:0];
		end
		return r;
	endfunction

	// apply the sign to a quotient magnitude and saturate
	function automatic logic [PW-1:0] sat_quo(input logic neg,
		input logic [mmsf_pkg::MAG_W-1:0] q);
		logic          over;
		logic [PW-1:0] r;
		if (neg) begin
			over = (|q[mmsf_pkg::MAG_W-1:PW]) || (q[PW-1] && (|q[PW-2:0]));
			r    = over ? {1'b1, {(PW-1){1'b0}}} : (~q[PW-1:0] + 1'b1);
		end else begin
			over = |q[mmsf_pkg::MAG_W-1:PW-1];
			r    = over ? {1'b0, {(PW-1){1'b1}}} : q[PW-1:0];
		end
		return r;
	endfunction

	// (a + b) / 2, halves away from zero
	function automatic logic [PW-1:0] avg2(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [PW+1:0] s;
		logic [PW+1:0] m;
		logic [PW+1:0] r;
		s = {{2{a[PW-1]}}, a} + {{2{b[PW-1]}}, b};
		if (s[PW+1]) begin
			m = ~s + 1'b1;
			r = (m + 1'b1) >> 1;
			r = ~r + 1'b1;
		end else begin
			r = (s + 1'b1) >> 1;
		end
		return r[PW-1:0];
	endfunction

	mmsf_pkg::state_t state_q;

	// configuration and long-lived state
	logic [mmsf_pkg::CFG_W-1:0]      weight_q;
	logic [mmsf_pkg::IDX_W-1:0]      ptr_q;
	logic [mmsf_pkg::IDX_W-1:0]      raddr_q;
	logic [mmsf_pkg::IDX_W-1:0]      tap_q;
	logic [mmsf_pkg::HIST_DEPTH-1:0] hvalid_q;
	logic                            seen_q;
	logic [PW-1:0]                   last_x_q;
	logic [PW-1:0]                   last_y_q;
	logic [PW-1:0]                   prior_x_q;
	logic [PW-1:0]                   prior_y_q;

	// datapath
	logic [mmsf_pkg::WT_W-1:0]         wt_q;
	logic [mmsf_pkg::TOT_W-1:0]        total_q;
	logic signed [mmsf_pkg::ACC_W-1:0] acc_x_q;
	logic signed [mmsf_pkg::ACC_W-1:0] acc_y_q;
	logic signed [mmsf_pkg::PROD_W-1:0] prod_q;
	logic                              neg_q;
	logic [PW-1:0]                     fx_q;
	logic [PW-1:0]                     fy_q;
	logic                              rd_valid_q;

	// output register
	logic          res_valid_q;
	logic [PW-1:0] move_x_q;
	logic [PW-1:0] move_y_q;

	logic                       accept;
	logic                       push;
	logic                       tap_last;
	logic                       out_free;
	logic [mmsf_pkg::IDX_W-1:0] ptr_new;
	logic [mmsf_pkg::IDX_W-1:0] raddr_inc;
	logic [PW-1:0]              mv_x;
	logic [PW-1:0]              mv_y;
	logic [2*PW-1:0]            rdata;
	logic signed [PW-1:0]       hist_x;
	logic signed [PW-1:0]       hist_y;

	logic signed [PW-1:0]              mul_a;
	logic signed [mmsf_pkg::WT_W:0]    mul_b;
	logic signed [PW+mmsf_pkg::WT_W:0] mul_p;
	logic [mmsf_pkg::WT_W+mmsf_pkg::CFG_W-1:0] wt_prod;
	logic [mmsf_pkg::WT_W-1:0]         wt_next;

	logic                       start_x;
	logic                       start_y;
	logic [mmsf_pkg::ACC_W-1:0] acc_sel;
	logic [mmsf_pkg::MAG_W-1:0] acc_mag;
	mmsf_pkg::div_req_t         div_req;
	mmsf_pkg::div_rsp_t         div_rsp;

	assign item_stall = (state_q != mmsf_pkg::S_IDLE);
	assign accept     = item_valid && !item_stall;
	// a cursor transaction before any cursor was seen only records the position
	assign push       = accept && (kind || seen_q);
	assign out_free   = !res_valid_q || !result_stall;
	assign tap_last   = (tap_q == mmsf_pkg::IDX_W'(mmsf_pkg::HIST_DEPTH - 1));

	// history is a circular buffer, newest entry at ptr_q, older ones above it
	assign ptr_new   = (ptr_q == '0) ? mmsf_pkg::IDX_W'(mmsf_pkg::HIST_DEPTH - 1)
	                                 : (ptr_q - 1'b1);
	assign raddr_inc = (raddr_q == mmsf_pkg::IDX_W'(mmsf_pkg::HIST_DEPTH - 1)) ? '0
	                                 : (raddr_q + 1'b1);

	// movement for this item
	assign mv_x = kind ? pos_x : sat33({pos_x[PW-1], pos_x} - {last_x_q[PW-1], last_x_q});
	assign mv_y = kind ? pos_y : sat33({pos_y[PW-1], pos_y} - {last_y_q[PW-1], last_y_q});

	mmsf_ram #(
		.WIDTH(2 * PW),
		.DEPTH(mmsf_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (push),
		.waddr (ptr_new),
		.wdata ({mv_x, mv_y}),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	// entries never written since reset read as zero
	assign hist_x = rd_valid_q ? rdata[2*PW-1:PW] : '0;
	assign hist_y = rd_valid_q ? rdata[PW-1:0] : '0;

	// shared multiplier: x tap in one cycle, y tap in the next
	assign mul_a = (state_q == mmsf_pkg::S_MX) ? hist_x : hist_y;
	assign mul_b = $signed({1'b0, wt_q});
	assign mul_p = mul_a * mul_b;

	// next geometric weight, rounded to nearest
	assign wt_prod = wt_q * weight_q;
	assign wt_next = mmsf_pkg::WT_W'((wt_prod + (mmsf_pkg::WT_W + mmsf_pkg::CFG_W)'(
		mmsf_pkg::RND_HALF)) >> mmsf_pkg::CFG_W);

	// divider requests: x after the last tap, y as soon as x is done
	assign start_x = (state_q == mmsf_pkg::S_AY) && tap_last;
	assign start_y = (state_q == mmsf_pkg::S_DVX) && div_rsp.done;
	assign acc_sel = start_x ? acc_x_q : acc_y_q;
	assign acc_mag = acc_sel[mmsf_pkg::ACC_W-1] ? (~acc_sel + 1'b1) : acc_sel;

	assign div_req.start = start_x || start_y;
	assign div_req.num   = acc_mag + mmsf_pkg::MAG_W'(total_q >> 1);
	assign div_req.den   = total_q;

	mmsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmsf_pkg::S_IDLE;
			weight_q    <= mmsf_pkg::DECAY_RESET;
			ptr_q       <= '0;
			raddr_q     <= '0;
			tap_q       <= '0;
			hvalid_q    <= '0;
			seen_q      <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			prior_x_q   <= '0;
			prior_y_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				weight_q <= cfg_wr_data;
			end
			// output register takes a new result, or empties once its transaction is taken
			if ((state_q == mmsf_pkg::S_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				mmsf_pkg::S_IDLE: begin
					if (accept && !kind) begin
						last_x_q <= pos_x;
						last_y_q <= pos_y;
						seen_q   <= 1'b1;
					end
					if (push) begin
						ptr_q             <= ptr_new;
						raddr_q           <= ptr_new;
						hvalid_q[ptr_new] <= 1'b1;
						tap_q             <= '0;
						state_q           <= mmsf_pkg::S_RD;
					end
				end
				mmsf_pkg::S_RD: begin
					state_q <= mmsf_pkg::S_MX;
				end
				mmsf_pkg::S_MX: begin
					// read data for this tap is already registered
					raddr_q <= raddr_inc;
					state_q <= mmsf_pkg::S_MY;
				end
				mmsf_pkg::S_MY: begin
					state_q <= mmsf_pkg::S_AY;
				end
				mmsf_pkg::S_AY: begin
					tap_q   <= tap_q + 1'b1;
					state_q <= tap_last ? mmsf_pkg::S_DVX : mmsf_pkg::S_MX;
				end
				mmsf_pkg::S_DVX: begin
					if (div_rsp.done) begin
						state_q <= mmsf_pkg::S_DVY;
					end
				end
				mmsf_pkg::S_DVY: begin
					if (div_rsp.done) begin
						state_q <= mmsf_pkg::S_OUT;
					end
				end
				mmsf_pkg::S_OUT: begin
					if (out_free) begin
						prior_x_q <= fx_q;
						prior_y_q <= fy_q;
						state_q   <= mmsf_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mmsf_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_valid_q <= hvalid_q[raddr_q];
		if (div_req.start) begin
			neg_q <= acc_sel[mmsf_pkg::ACC_W-1];
		end
		case (state_q)
			mmsf_pkg::S_IDLE: begin
				if (push) begin
					acc_x_q <= '0;
					acc_y_q <= '0;
					total_q <= '0;
					wt_q    <= mmsf_pkg::WT_ONE;
				end
			end
			mmsf_pkg::S_MX: begin
				prod_q  <= mul_p[mmsf_pkg::PROD_W-1:0];
				total_q <= total_q + mmsf_pkg::TOT_W'(wt_q);
			end
			mmsf_pkg::S_MY: begin
				acc_x_q <= acc_x_q + mmsf_pkg::ACC_W'(prod_q);
				prod_q  <= mul_p[mmsf_pkg::PROD_W-1:0];
			end
			mmsf_pkg::S_AY: begin
				acc_y_q <= acc_y_q + mmsf_pkg::ACC_W'(prod_q);
				wt_q    <= wt_next;
			end
			mmsf_pkg::S_DVX: begin
				if (div_rsp.done) begin
					fx_q <= sat_quo(neg_q, div_rsp.quo);
				end
			end
			mmsf_pkg::S_DVY: begin
				if (div_rsp.done) begin
					fy_q <= sat_quo(neg_q, div_rsp.quo);
				end
			end
			mmsf_pkg::S_OUT: begin
				if (out_free) begin
					move_x_q <= avg2(fx_q, prior_x_q);
					move_y_q <= avg2(fy_q, prior_y_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign move_x       = move_x_q;
	assign move_y       = move_y_q;

`ifndef SYNTHESIS
	// a relative movement always starts the filter sequence
	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && kind) |=> item_stall)
		else $error("relative movement did not start the filter");

	// the divider is never restarted in the middle of a pass
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (!div_rsp.busy || div_rsp.done))
		else $error("divider started while busy");

	// the newest weight alone is one, so the divisor never falls below it
	a_den_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmsf_pkg::S_DVX) |-> (total_q >= mmsf_pkg::TOT_W'(mmsf_pkg::WT_ONE)))
		else $error("weight sum below one");

	// a pending result is never overwritten by the next one
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmsf_pkg::S_OUT && res_valid_q && result_stall)
		|=> (state_q == mmsf_pkg::S_OUT) && $stable(move_x_q) && $stable(move_y_q))
		else $error("result register overwritten while stalled");
`endif

endmodule

// ===== tb/sv/mouse_motion_smoothing_filter_test.sv =====
module mouse_motion_smoothing_filter_test;

	// block constants taken from the package
	localparam int               POS_W       = mmsf_pkg::POS_W;
	localparam int               CFG_W       = mmsf_pkg::CFG_W;
	localparam int               HIST_DEPTH  = mmsf_pkg::HIST_DEPTH;
	localparam int               RND_HALF    = mmsf_pkg::RND_HALF;
	localparam logic [CFG_W-1:0] DECAY_RESET = mmsf_pkg::DECAY_RESET;
	localparam logic [mmsf_pkg::WT_W-1:0] WT_ONE = mmsf_pkg::WT_ONE;

	// item kinds as carried on the kind port
	localparam logic KIND_CURSOR = 1'b0;
	localparam logic KIND_MOVE   = 1'b1;

	// covers any movement work still in flight
	localparam int SETTLE_CYCLES = 200;
	// long receiver hold-off, far beyond what the output register can absorb
	localparam int HOLD_CYCLES   = 1500;
	// run-length limit for the whole test
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_CHUNK  = 140;

	localparam longint POS_TOP = (longint'(1) <<< (POS_W - 1)) - 1;
	localparam longint POS_BOT = -(longint'(1) <<< (POS_W - 1));

	typedef logic signed [POS_W-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
	} move_t;

	// block ports
	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             item_valid;
	logic             item_stall;
	logic             kind;
	coord_t           pos_x;
	coord_t           pos_y;
	logic             result_valid;
	logic             result_stall = 1'b1;
	coord_t           move_x;
	coord_t           move_y;

	// idling controls, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// hold-off request from the test, served by the stall process
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int errors      = 0;
	int cycle_count = 0;

	// predictor state, reset values
	logic [CFG_W-1:0] decay_now   = DECAY_RESET;
	coord_t           hist_dx[HIST_DEPTH] = '{default: '0};
	coord_t           hist_dy[HIST_DEPTH] = '{default: '0};
	coord_t           prev_mean_x = '0;
	coord_t           prev_mean_y = '0;
	coord_t           cursor_x    = '0;
	coord_t           cursor_y    = '0;
	logic             have_cursor = 1'b0;

	// smoothed movements still owed by the block, oldest first
	move_t pending_moves[$];

	// generator state for well-formed cursor walks
	coord_t walk_x = '0;
	coord_t walk_y = '0;

	mouse_motion_smoothing_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.move_x       (move_x),
		.move_y       (move_y)
	);

	always #5 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("mouse_motion_smoothing_filter_test: errors");
			$finish;
		end
	end

	// receiver side: random stall, or a long hold-off when the test asks for one
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// compare every accepted result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		move_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_moves.size() == 0) begin
				$display("%0t: result with none expected, move_x %0d move_y %0d",
					$time, move_x, move_y);
				errors++;
			end else begin
				want = pending_moves.pop_front();
				if (move_x !== want.x) begin
					$display("%0t: move_x expected %0d actual %0d", $time, want.x, move_x);
					errors++;
				end
				if (move_y !== want.y) begin
					$display("%0t: move_y expected %0d actual %0d", $time, want.y, move_y);
					errors++;
				end
			end
		end
	end

	// saturate to the signed Q24.8 range
	function automatic coord_t clamp_pos(input longint v);
		if (v > POS_TOP)
			return coord_t'(POS_TOP);
		if (v < POS_BOT)
			return coord_t'(POS_BOT);
		return coord_t'(v);
	endfunction

	// divide rounding to nearest, halves away from zero, den > 0
	function automatic longint round_half_away(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	// advance the predicted filter by one accepted item and queue its result, if any
	task automatic smooth_movement(input logic k, input coord_t x, input coord_t y);
		longint dx, dy, sum_x, sum_y, wt, wt_total, mean_x, mean_y;
		move_t  m;
		int     i;
		if (k == KIND_CURSOR) begin
			// the first cursor position only becomes the reference point
			if (!have_cursor) begin
				cursor_x    = x;
				cursor_y    = y;
				have_cursor = 1'b1;
				return;
			end
			dx = clamp_pos(longint'(x) - longint'(cursor_x));
			dy = clamp_pos(longint'(y) - longint'(cursor_y));
			cursor_x = x;
			cursor_y = y;
		end else begin
			dx = x;
			dy = y;
		end

		// newest movement at the head of the history
		for (i = HIST_DEPTH - 1; i > 0; i--) begin
			hist_dx[i] = hist_dx[i-1];
			hist_dy[i] = hist_dy[i-1];
		end
		hist_dx[0] = coord_t'(dx);
		hist_dy[0] = coord_t'(dy);

		// geometric weights in Q16.16, each rounded from the one before
		sum_x    = 0;
		sum_y    = 0;
		wt       = WT_ONE;
		wt_total = 0;
		for (i = 0; i < HIST_DEPTH; i++) begin
			sum_x    += longint'(hist_dx[i]) * wt;
			sum_y    += longint'(hist_dy[i]) * wt;
			wt_total += wt;
			wt = (wt * longint'(decay_now) + RND_HALF) >> 16;
		end
		mean_x = clamp_pos(round_half_away(sum_x, wt_total));
		mean_y = clamp_pos(round_half_away(sum_y, wt_total));

		// two-tap average with the previous mean
		m.x = clamp_pos(round_half_away(mean_x + longint'(prev_mean_x), 2));
		m.y = clamp_pos(round_half_away(mean_y + longint'(prev_mean_y), 2));
		prev_mean_x = coord_t'(mean_x);
		prev_mean_y = coord_t'(mean_y);
		pending_moves.push_back(m);
	endtask

	// offer one item transaction, with random idle cycles ahead of it
	task automatic send_item(input logic k, input coord_t x, input coord_t y);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		pos_x      <= x;
		pos_y      <= y;
		do
			@(posedge clk);
		while (item_stall);
		smooth_movement(k, x, y);
	endtask

	// stop offering, let every owed result out, then let any leftover work finish
	task automatic settle_block();
		item_valid <= 1'b0;
		while (pending_moves.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// weight_decay is only written with the block idle
	task automatic write_decay(input logic [CFG_W-1:0] v);
		settle_block();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		decay_now = v;
	endtask

	// signed step of random magnitude class
	function automatic coord_t rand_step();
		int r;
		case ($urandom_range(3))
			0: r = 256;
			1: r = 1 << 16;
			2: r = 1 << 24;
			default: return '0;
		endcase
		return coord_t'($urandom_range(0, 2 * r)) - coord_t'(r);
	endfunction

	function automatic coord_t rand_extreme();
		case ($urandom_range(3))
			0: return coord_t'(POS_TOP);
			1: return coord_t'(POS_BOT);
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] rand_decay();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			default: return CFG_W'($urandom_range(65535));
		endcase
	endfunction

	// mostly cursor walks and plausible movements, some raw noise and extremes
	task automatic send_random_item();
		logic   k;
		coord_t x, y;
		int     sel;
		sel = $urandom_range(99);
		if (sel < 45) begin
			k = KIND_CURSOR;
			walk_x = walk_x + rand_step();
			walk_y = walk_y + rand_step();
			x = walk_x;
			y = walk_y;
		end else if (sel < 85) begin
			k = KIND_MOVE;
			x = rand_step();
			y = rand_step();
		end else begin
			k = 1'($urandom_range(1));
			if (sel < 95) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = rand_extreme();
				y = rand_extreme();
			end
			// a jump restarts the walk from wherever the cursor landed
			if (k == KIND_CURSOR) begin
				walk_x = x;
				walk_y = y;
			end
		end
		send_item(k, x, y);
	endtask

	// first cursor only records, later cursors give deltas, relatives leave the cursor alone
	task automatic test_cursor_start();
		send_item(KIND_CURSOR, 32'sd100, -32'sd200);
		send_item(KIND_CURSOR, 32'sd356, -32'sd456);
		send_item(KIND_MOVE, 32'sd0, 32'sd0);
		send_item(KIND_MOVE, 32'sd77, -32'sd77);
		send_item(KIND_CURSOR, 32'sd356, -32'sd456);
	endtask

	// field extremes, and cursor deltas that overflow in both directions
	task automatic test_field_extremes();
		send_item(KIND_MOVE, coord_t'(POS_TOP), coord_t'(POS_BOT));
		send_item(KIND_MOVE, coord_t'(POS_BOT), coord_t'(POS_TOP));
		send_item(KIND_MOVE, -32'sd1, 32'sd1);
		send_item(KIND_CURSOR, coord_t'(POS_TOP), coord_t'(POS_BOT));
		send_item(KIND_CURSOR, coord_t'(POS_BOT), coord_t'(POS_TOP));
		send_item(KIND_CURSOR, coord_t'(POS_TOP), coord_t'(POS_BOT));
		send_item(KIND_MOVE, coord_t'(POS_TOP), coord_t'(POS_TOP));
	endtask

	// zero decay keeps only the newest movement, full decay weights all nearly alike
	task automatic test_decay_extremes();
		write_decay('0);
		send_item(KIND_MOVE, 32'sd1000, -32'sd1000);
		// odd sum with the prior lands on a half
		send_item(KIND_MOVE, 32'sd1, -32'sd1);
		write_decay('1);
		send_item(KIND_MOVE, coord_t'(POS_TOP), coord_t'(POS_BOT));
		send_item(KIND_MOVE, coord_t'(POS_TOP), coord_t'(POS_BOT));
		send_item(KIND_MOVE, coord_t'(POS_BOT), coord_t'(POS_TOP));
		write_decay(CFG_W'(1));
		send_item(KIND_MOVE, -32'sd3, 32'sd3);
		send_item(KIND_CURSOR, 32'sd0, 32'sd0);
	endtask

	// random traffic under three idling patterns, a fresh decay for each chunk
	task automatic test_random_traffic();
		int send_pcts[3] = '{19, 68, 0};
		int recv_pcts[3] = '{68, 19, 0};
		for (int p = 0; p < 3; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int c = 0; c < 4; c++) begin
				write_decay(rand_decay());
				repeat (RANDOM_CHUNK) send_random_item();
			end
		end
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_output_backpressure();
		write_decay(DECAY_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_asks++;
		repeat (40) send_random_item();
		settle_block();
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		item_valid  <= 1'b0;
		kind        <= KIND_MOVE;
		pos_x       <= '0;
		pos_y       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_cursor_start();
		test_field_extremes();
		test_decay_extremes();
		test_random_traffic();
		test_output_backpressure();

		settle_block();
		if (errors == 0)
			$display("mouse_motion_smoothing_filter_test: clean");
		else
			$display("mouse_motion_smoothing_filter_test: errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/mmsf_pkg.sv
src/mmsf_ram.sv
src/mmsf_div.sv
src/mouse_motion_smoothing_filter.sv
tb/sv/mouse_motion_smoothing_filter_test.sv
